// File: rtl/core/ddo_pkg.sv
// shared constants, types and tables for the differential drive odometry block
package ddo_pkg;

  localparam int CordicSteps = 16;
  localparam int StepW = $clog2(CordicSteps + 1);

  localparam logic signed [19:0] PiQ16     = 20'sd205887;
  localparam logic signed [19:0] HalfPiQ16 = 20'sd102944;
  localparam logic signed [20:0] TwoPiQ16  = 21'sd411775;
  localparam logic signed [33:0] CordicK   = 34'sd652032874;

  localparam logic [15:0] WheelRadiusRst = 16'd2163;
  localparam logic [19:0] InvAxleRst     = 20'd415574;

  localparam logic [0:0] CfgWheelRadius = 1'd0;
  localparam logic [0:0] CfgInvAxle     = 1'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ARC,
    ST_THETA,
    ST_ROT,
    ST_MUL,
    ST_POSE,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic load;
    logic first;
    logic do_arc;
    logic do_theta;
    logic rot_start;
    logic rot_step;
    logic do_mul;
    logic do_pose;
  } dp_cmd_t;

  typedef struct packed {
    logic rot_done;
  } dp_stat_t;

  function automatic logic signed [31:0] atan_q30(input logic [4:0] i);
    case (i)
      5'd0:  atan_q30 = 32'sd843314857;
      5'd1:  atan_q30 = 32'sd497837829;
      5'd2:  atan_q30 = 32'sd263043837;
      5'd3:  atan_q30 = 32'sd133525159;
      5'd4:  atan_q30 = 32'sd67021687;
      5'd5:  atan_q30 = 32'sd33543516;
      5'd6:  atan_q30 = 32'sd16775851;
      5'd7:  atan_q30 = 32'sd8388437;
      5'd8:  atan_q30 = 32'sd4194283;
      5'd9:  atan_q30 = 32'sd2097149;
      5'd10: atan_q30 = 32'sd1048576;
      5'd11: atan_q30 = 32'sd524288;
      5'd12: atan_q30 = 32'sd262144;
      5'd13: atan_q30 = 32'sd131072;
      5'd14: atan_q30 = 32'sd65536;
      5'd15: atan_q30 = 32'sd32768;
      5'd16: atan_q30 = 32'sd16384;
      5'd17: atan_q30 = 32'sd8192;
      5'd18: atan_q30 = 32'sd4096;
      5'd19: atan_q30 = 32'sd2048;
      5'd20: atan_q30 = 32'sd1024;
      5'd21: atan_q30 = 32'sd512;
      5'd22: atan_q30 = 32'sd256;
      5'd23: atan_q30 = 32'sd128;
      default: atan_q30 = 32'sd0;
    endcase
  endfunction

endpackage

// File: rtl/core/diff_drive_odometry.sv
// top level of the differential drive odometry block
//  channel | signals                                   | dir
//  input   | in_valid_i, in_stall_o, right/left angle  | in
//  output  | out_valid_o, out_stall_i, pos_x/y, heading| out
//  config  | cfg_valid_i, cfg_ready_o, cfg_index_i/data| in
// one item goes through accept, arcs, heading change, a load of the
// cordic and 16 steps at one per cycle plus the done check, product, pose update, result.
// the first item after reset only latches the angles and goes straight to the result.
// reset clears the pose, the latched angles and the config registers to their defaults.
// the result holds on out_stall_i; no new item is taken until it has been taken.
module diff_drive_odometry (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [31:0] right_wheel_angle_i,
  input  logic signed [31:0] left_wheel_angle_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] pos_x_o,
  output logic signed [31:0] pos_y_o,
  output logic [18:0]        heading_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [31:0]        cfg_index_i,
  input  logic [31:0]        cfg_data_i
);
  import ddo_pkg::*;

  logic [15:0] wheel_radius_q;
  logic [19:0] inv_axle_q;
  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic first;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wheel_radius_q <= WheelRadiusRst;
      inv_axle_q <= InvAxleRst;
    end else if (cfg_valid_i && cfg_index_i[31:1] == '0) begin
      if (cfg_index_i[0] == CfgWheelRadius) wheel_radius_q <= cfg_data_i[15:0];
      if (cfg_index_i[0] == CfgInvAxle) inv_axle_q <= cfg_data_i[19:0];
    end
  end

  ddo_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .first_i(first), .cmd_o(cmd), .stat_i(stat)
  );

  ddo_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .stat_o(stat),
    .right_wheel_angle_i, .left_wheel_angle_i,
    .wheel_radius_i(wheel_radius_q), .inv_axle_length_i(inv_axle_q),
    .first_o(first), .pos_x_o, .pos_y_o, .heading_o
  );

  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(out_valid_o && !in_stall_o)) else $error("accept while result pending");
  a_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> heading_o <= 19'd411775) else $error("heading out of range");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> $stable(pos_x_o) && $stable(heading_o))
    else $error("result changed while stalled");
endmodule

// File: rtl/core/ddo_ctrl.sv
// sequencer for one odometry update
module ddo_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  logic              first_i,
  output ddo_pkg::dp_cmd_t  cmd_o,
  input  ddo_pkg::dp_stat_t stat_i
);
  import ddo_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = first_i ? ST_OUT : ST_ARC;
        end
      end
      ST_ARC:   state_d = ST_THETA;
      ST_THETA: state_d = ST_ROT;
      ST_ROT: begin
        if (stat_i.rot_done) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL:  state_d = ST_POSE;
      ST_POSE: state_d = ST_OUT;
      ST_OUT: begin
        if (!out_stall_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    in_stall_o = 1'b1;
    out_valid_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
        cmd_o.first = in_valid_i & first_i;
      end
      ST_ARC:   cmd_o.do_arc = 1'b1;
      ST_THETA: begin
        cmd_o.do_theta = 1'b1;
      end
      ST_ROT: begin
        cmd_o.rot_step = 1'b1;
      end
      ST_MUL:  cmd_o.do_mul = 1'b1;
      ST_POSE: cmd_o.do_pose = 1'b1;
      ST_OUT:  out_valid_o = 1'b1;
      default: cmd_o = '0;
    endcase
    cmd_o.rot_start = (state_q == ST_THETA);
  end
endmodule

// File: rtl/core/ddo_datapath.sv
// arcs, heading change, iterative cordic and pose update
module ddo_datapath (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  ddo_pkg::dp_cmd_t         cmd_i,
  output ddo_pkg::dp_stat_t        stat_o,
  input  logic signed [31:0]       right_wheel_angle_i,
  input  logic signed [31:0]       left_wheel_angle_i,
  input  logic [15:0]              wheel_radius_i,
  input  logic [19:0]              inv_axle_length_i,
  output logic                     first_o,
  output logic signed [31:0]       pos_x_o,
  output logic signed [31:0]       pos_y_o,
  output logic [18:0]              heading_o
);
  import ddo_pkg::*;

  logic        first_q;
  logic [31:0] last_r_q, last_l_q;
  logic signed [31:0] dr_q, dl_q;
  logic signed [32:0] arc_r_q, arc_l_q;
  logic signed [32:0] mean_q;
  logic signed [19:0] dth_q;
  logic        neg_cos_q;
  logic signed [33:0] cx_q, cy_q, cz_q;
  logic [StepW-1:0] step_q;
  logic signed [37:0] dx_q, dy_q;
  logic signed [31:0] px_q, py_q;
  logic [18:0] hd_q;
  logic        rot_init_q;

  // arc = round(delta * radius / 2^16)
  logic signed [48:0] pr, pl;
  assign pr = dr_q * $signed({1'b0, wheel_radius_i}) + 49'sd32768;
  assign pl = dl_q * $signed({1'b0, wheel_radius_i}) + 49'sd32768;

  // heading change
  logic signed [33:0] arc_diff;
  logic signed [55:0] dth_full;
  logic signed [39:0] dth_r;
  logic signed [19:0] dth_sat;
  assign arc_diff = {arc_r_q[32], arc_r_q} - {arc_l_q[32], arc_l_q};
  assign dth_full = arc_diff * $signed({1'b0, inv_axle_length_i}) + 56'sd32768;
  assign dth_r = dth_full[55:16];
  always_comb begin
    if (dth_r > 40'(PiQ16)) dth_sat = PiQ16;
    else if (dth_r < -40'(PiQ16)) dth_sat = -PiQ16;
    else dth_sat = dth_r[19:0];
  end

  // mid-step angle folded into [-pi/2, pi/2]
  logic signed [20:0] mid0, mid1, mid2;
  logic mid_neg;
  always_comb begin
    mid0 = $signed({2'b00, hd_q}) + 21'(dth_q >>> 1);
    mid1 = (mid0 > 21'(PiQ16)) ? mid0 - TwoPiQ16 : mid0;
    mid_neg = 1'b0;
    mid2 = mid1;
    if (mid1 > 21'(HalfPiQ16)) begin
      mid2 = 21'(PiQ16) - mid1;
      mid_neg = 1'b1;
    end else if (mid1 < -21'(HalfPiQ16)) begin
      mid2 = -21'(PiQ16) - mid1;
      mid_neg = 1'b1;
    end
  end

  // one cordic step per cycle
  logic signed [33:0] xs, ys, at;
  assign xs = cx_q >>> step_q;
  assign ys = cy_q >>> step_q;
  assign at = 34'(atan_q30(5'(step_q)));
  assign stat_o.rot_done = (step_q == StepW'(CordicSteps));

  // position increments, one product each
  logic signed [33:0] cos_v;
  logic signed [67:0] mx, my;
  logic signed [37:0] rx, ry;
  assign cos_v = neg_cos_q ? -cx_q : cx_q;
  assign mx = 68'(mean_q) * 68'(cos_v) + 68'sd536870912;
  assign my = 68'(mean_q) * 68'(cy_q) + 68'sd536870912;
  assign rx = mx[67:30];
  assign ry = my[67:30];

  function automatic logic signed [31:0] sat38(input logic signed [37:0] v);
    if (v > 38'sd2147483647) sat38 = 32'sh7fffffff;
    else if (v < -38'sd2147483648) sat38 = 32'sh80000000;
    else sat38 = v[31:0];
  endfunction

  logic signed [20:0] hsum;
  assign hsum = $signed({2'b00, hd_q}) + 21'(dth_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q <= 1'b1;
      last_r_q <= '0;
      last_l_q <= '0;
      px_q <= '0;
      py_q <= '0;
      hd_q <= '0;
      step_q <= '0;
    end else begin
      if (cmd_i.load) begin
        dr_q <= right_wheel_angle_i - last_r_q;
        dl_q <= left_wheel_angle_i - last_l_q;
        last_r_q <= right_wheel_angle_i;
        last_l_q <= left_wheel_angle_i;
        first_q <= 1'b0;
        if (cmd_i.first) begin
          px_q <= '0;
          py_q <= '0;
          hd_q <= '0;
        end
      end
      if (cmd_i.do_arc) begin
        arc_r_q <= pr[48:16];
        arc_l_q <= pl[48:16];
        mean_q <= 33'(($signed({pr[48], pr[48:16]}) + $signed({pl[48], pl[48:16]})) >>> 1);
      end
      if (cmd_i.do_theta) dth_q <= dth_sat;
      if (cmd_i.rot_start) begin
        step_q <= '0;
      end else if (cmd_i.rot_step && !rot_init_q && !stat_o.rot_done) begin
        step_q <= step_q + 1'b1;
      end
      if (cmd_i.do_pose) begin
        px_q <= sat38(38'(px_q) + dx_q);
        py_q <= sat38(38'(py_q) + dy_q);
        if (hsum > 21'(TwoPiQ16)) hd_q <= 19'(hsum - TwoPiQ16);
        else if (hsum < 0) hd_q <= 19'(hsum + TwoPiQ16);
        else hd_q <= hsum[18:0];
      end
    end
  end

  // dth is ready in the cycle after do_theta, so fold uses dth_q in the first rot cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) rot_init_q <= 1'b0;
    else rot_init_q <= cmd_i.rot_start;
  end

  always_ff @(posedge clk_i) begin
    if (rot_init_q) begin
      cx_q <= CordicK;
      cy_q <= '0;
      cz_q <= 34'(mid2) <<< 14;
      neg_cos_q <= mid_neg;
    end else if (cmd_i.rot_step && !stat_o.rot_done) begin
      if (!cz_q[33]) begin
        cx_q <= cx_q - ys; cy_q <= cy_q + xs; cz_q <= cz_q - at;
      end else begin
        cx_q <= cx_q + ys; cy_q <= cy_q - xs; cz_q <= cz_q + at;
      end
    end
    if (cmd_i.do_mul) begin
      dx_q <= rx;
      dy_q <= ry;
    end
  end

  assign first_o = first_q;
  assign pos_x_o = px_q;
  assign pos_y_o = py_q;
  assign heading_o = hd_q;
endmodule
